/* rtl/core/clwd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clwd_pkg
// Shared types and constants for the per-CPU lockup watchdog.
// ----------------------------------------------------------------------------
package clwd_pkg;

    localparam int NUM_CPUS    = 8;
    localparam int CPU_W       = 3;
    localparam int CPU_IDX_W   = $clog2(NUM_CPUS);
    localparam int COUNT_WIDTH = 32;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 8;
    localparam int MASK_W      = 8;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;

    // heartbeat phase modulo the check interval (every third tick)
    localparam int CHECK_EVERY = 3;
    localparam int PHASE_W     = 2;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CHECK_EVERY - 1);

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 8'd5;
    localparam logic [MASK_W-1:0] ONLINE_RESET    = 8'hFF;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RAN   = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'd0,
        CFG_ONLINE    = 1'd1
    } cfg_idx_t;

    localparam logic [1:0] HARD_NONE = 2'd0;
    localparam logic [1:0] HARD_DET  = 2'd1;
    localparam logic [1:0] HARD_REC  = 2'd2;

    localparam logic [1:0] SOFT_NONE = 2'd0;
    localparam logic [1:0] SOFT_DET  = 2'd1;
    localparam logic [1:0] SOFT_END  = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [CPU_W-1:0]  cpu;
        logic [TIME_W-1:0] now_seconds;
    } clwd_in_t;

    typedef struct packed {
        logic [1:0]        hard_event;
        logic [CPU_W-1:0]  hard_cpu;
        logic [31:0]       hard_count;
        logic [31:0]       hard_prev_count;
        logic              wake_request;
        logic [1:0]        soft_event;
        logic [31:0]       stuck_seconds;
        logic [31:0]       tick_count;
    } clwd_out_t;

    typedef struct packed {
        logic                 found;
        logic [CPU_IDX_W-1:0] idx;
    } clwd_nbr_t;

endpackage : clwd_pkg
`default_nettype wire

/* rtl/core/cpu_lockup_watchdog_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_lockup_watchdog_unit
// Per-CPU soft lockup and neighbour-checked hard lockup watchdog.
//
//   channel | signals                    | payload
//   --------+----------------------------+------------------------------
//   in      | in_valid / in_stall        | in_data  (clwd_in_t)
//   out     | out_valid / out_stall      | out_data (clwd_out_t)
//   cfg     | cfg_we, cfg_index          | cfg_wdata (threshold, mask)
//
// One beat per cycle while out_stall is low; an accepted event loads the input
// register, and the evaluation over the per-CPU registers is then loaded into
// the output register, from which the result beat is presented.
// Every event gives exactly one result beat.
// Reset clears all per-CPU state and loads threshold 5, all CPUs online.
// out_stall holds the output register; in_stall rises only when both the
// input register and the output register are full and out_stall is high.
// ----------------------------------------------------------------------------
module cpu_lockup_watchdog_unit
    import clwd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire clwd_in_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output clwd_out_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    logic              s1_valid_reg;
    clwd_in_t          s1_item_reg;
    logic              out_valid_reg;
    clwd_out_t         out_data_reg;
    logic [THR_W-1:0]  threshold_reg;
    logic [MASK_W-1:0] online_reg;
    logic              advance;
    logic              in_take;
    clwd_out_t         result;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    clwd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (advance),
        .item        (s1_item_reg),
        .threshold   (threshold_reg),
        .online_mask (online_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            online_reg    <= ONLINE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_wdata[THR_W-1:0];
                CFG_ONLINE:    online_reg    <= cfg_wdata[MASK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

endmodule : cpu_lockup_watchdog_unit
`default_nettype wire

/* rtl/core/clwd_nbr_sel.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clwd_nbr_sel
// Finds the next online CPU after a given one, wrapping round the mask.
// ----------------------------------------------------------------------------
module clwd_nbr_sel
    import clwd_pkg::*;
(
    input  wire logic [CPU_IDX_W-1:0] cpu,
    input  wire logic [MASK_W-1:0]    online_mask,
    output clwd_nbr_t                 nbr
);

    always_comb
    begin
        logic [CPU_IDX_W-1:0] cand;
        logic                 online;
        nbr = '0;
        // walk from farthest to nearest so the nearest hit wins
        for (int k = NUM_CPUS - 1; k >= 1; k--)
        begin
            cand   = cpu + CPU_IDX_W'(k);
            online = (int'(cand) < MASK_W) ? online_mask[cand] : 1'b0;
            if (online)
            begin
                nbr.found = 1'b1;
                nbr.idx   = cand;
            end
        end
    end

endmodule : clwd_nbr_sel
`default_nettype wire

/* rtl/core/clwd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clwd_core
// Per-CPU watchdog state and the single-pass event evaluation.
// ----------------------------------------------------------------------------
module clwd_core
    import clwd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             commit,
    input  wire clwd_in_t         item,
    input  wire logic [THR_W-1:0] threshold,
    input  wire logic [MASK_W-1:0] online_mask,
    output clwd_out_t             result
);

    logic [COUNT_WIDTH-1:0] hb_reg     [NUM_CPUS];
    logic [COUNT_WIDTH-1:0] hb_next    [NUM_CPUS];
    logic [PHASE_W-1:0]     phase_reg  [NUM_CPUS];
    logic [PHASE_W-1:0]     phase_next [NUM_CPUS];
    logic [COUNT_WIDTH-1:0] saved_reg  [NUM_CPUS];
    logic [COUNT_WIDTH-1:0] saved_next [NUM_CPUS];
    logic [TIME_W-1:0]      touch_reg  [NUM_CPUS];
    logic [TIME_W-1:0]      touch_next [NUM_CPUS];
    logic [NUM_CPUS-1:0]    kick_reg,   kick_next;
    logic [NUM_CPUS-1:0]    thread_reg, thread_next;
    logic [NUM_CPUS-1:0]    soft_reg,   soft_next;
    logic [NUM_CPUS-1:0]    hard_reg,   hard_next;

    logic [CPU_IDX_W-1:0]   c;
    logic                   cpu_ok;
    clwd_nbr_t              nbr;

    assign c      = item.cpu[CPU_IDX_W-1:0];
    assign cpu_ok = (int'(item.cpu) < NUM_CPUS);

    clwd_nbr_sel u_nbr_sel
    (
        .cpu         (c),
        .online_mask (online_mask),
        .nbr         (nbr)
    );

    always_comb
    begin
        logic [COUNT_WIDTH-1:0] ticks;
        logic [PHASE_W-1:0]     phase_t;
        logic                   check;
        logic [COUNT_WIDTH-1:0] nbt;
        logic [COUNT_WIDTH-1:0] nb_saved;
        logic                   same;
        logic                   wake;
        logic [TIME_W-1:0]      ts;
        logic [TIME_W+1:0]      limit;
        logic                   over;

        hb_next     = hb_reg;
        phase_next  = phase_reg;
        saved_next  = saved_reg;
        touch_next  = touch_reg;
        kick_next   = kick_reg;
        thread_next = thread_reg;
        soft_next   = soft_reg;
        hard_next   = hard_reg;
        result      = '0;

        ticks = hb_reg[c] + COUNT_WIDTH'(1);
        // phase tracks ticks mod 3; a wrap to zero lands back on phase zero
        if (ticks == '0 || phase_reg[c] == PHASE_LAST)
            phase_t = '0;
        else
            phase_t = phase_reg[c] + PHASE_W'(1);
        check    = (phase_t == '0) && nbr.found;
        nbt      = hb_reg[nbr.idx];
        nb_saved = saved_reg[nbr.idx];
        same     = (nb_saved == nbt);
        wake     = !kick_reg[c] && thread_reg[c];
        ts       = touch_reg[c];
        limit    = {2'b00, ts} + {{(TIME_W + 1 - THR_W){1'b0}}, threshold, 1'b0};
        over     = (ts != '0) && ({2'b00, item.now_seconds} > limit);

        if (cpu_ok)
        begin
            case (item.action)
                ACT_TICK:
                begin
                    hb_next[c]        = ticks;
                    phase_next[c]     = phase_t;
                    result.tick_count = ticks[31:0];
                    if (check)
                    begin
                        result.hard_cpu   = CPU_W'(nbr.idx);
                        result.hard_count = nbt[31:0];
                        if (same)
                        begin
                            if (!hard_reg[nbr.idx])
                            begin
                                hard_next[nbr.idx] = 1'b1;
                                result.hard_event  = HARD_DET;
                            end
                        end
                        else
                        begin
                            if (hard_reg[nbr.idx])
                            begin
                                result.hard_event      = HARD_REC;
                                result.hard_prev_count = nb_saved[31:0];
                                hard_next[nbr.idx]     = 1'b0;
                            end
                            saved_next[nbr.idx] = nbt;
                        end
                    end
                    if (wake)
                    begin
                        kick_next[c]        = 1'b1;
                        result.wake_request = 1'b1;
                    end
                    if (over)
                    begin
                        if (!soft_reg[c])
                        begin
                            soft_next[c]         = 1'b1;
                            result.soft_event    = SOFT_DET;
                            result.stuck_seconds = item.now_seconds - ts;
                        end
                    end
                    else if (soft_reg[c] && ts != '0)
                    begin
                        soft_next[c]      = 1'b0;
                        result.soft_event = SOFT_END;
                    end
                end
                ACT_RAN:
                begin
                    if (thread_reg[c])
                    begin
                        kick_next[c]  = 1'b0;
                        touch_next[c] = item.now_seconds;
                    end
                end
                ACT_START:
                begin
                    if (!thread_reg[c])
                    begin
                        thread_next[c] = 1'b1;
                        kick_next[c]   = 1'b0;
                        soft_next[c]   = 1'b0;
                        hard_next[c]   = 1'b0;
                        touch_next[c]  = item.now_seconds;
                    end
                end
                default:
                begin
                    thread_next[c] = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                hb_reg[i]    <= '0;
                phase_reg[i] <= '0;
                saved_reg[i] <= '0;
                touch_reg[i] <= '0;
            end
            kick_reg   <= '0;
            thread_reg <= '0;
            soft_reg   <= '0;
            hard_reg   <= '0;
        end
        else if (commit)
        begin
            hb_reg     <= hb_next;
            phase_reg  <= phase_next;
            saved_reg  <= saved_next;
            touch_reg  <= touch_next;
            kick_reg   <= kick_next;
            thread_reg <= thread_next;
            soft_reg   <= soft_next;
            hard_reg   <= hard_next;
        end
    end

endmodule : clwd_core
`default_nettype wire

/* rtl/core/clwd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clwd_port_checks
// Port-level checks on the lockup watchdog, bound to the top level.
// ----------------------------------------------------------------------------
module clwd_port_checks
    import clwd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire clwd_in_t             in_data,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire clwd_out_t            out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // a stalled event beat is held by the sender
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("event beat changed while stalled");

    // with the output side empty the input side never stalls
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output register");

    a_prev_only_rec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hard_event != HARD_REC |-> out_data.hard_prev_count == '0)
        else $error("hard_prev_count set without recovery");

    a_stuck_only_det: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.soft_event != SOFT_DET |-> out_data.stuck_seconds == '0)
        else $error("stuck_seconds set without soft lockup");

endmodule : clwd_port_checks

bind cpu_lockup_watchdog_unit clwd_port_checks u_clwd_port_checks (.*);
`default_nettype wire
